### design/rspb_pkg.sv
// Shared types and constants for the run-length sprite blitter.
package rspb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 160;
    localparam int SCREEN_HEIGHT_DEF = 168;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [3:0] PRIO_CTRL   = 4'h3;
    localparam logic [3:0] PRIO_BOTTOM = 4'h4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CEL   = 2'd2,
        OP_RUN   = 2'd3
    } t_op;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_CEL  = 1'b1
    } t_kind;

    typedef struct packed {
        logic pix_write;
        logic pix_read;
        logic cel_start;
        logic row_end;
        logic run_load;
        logic rd_cursor;
        logic rd_walk;
        logic save_real;
        logic plot;
        logic plot_chk;
        logic plot_bottom;
        logic step;
        logic push_read;
        logic push_done;
    } t_cmd;

    typedef struct packed {
        logic rows_zero;
        logic rows_one;
        logic run_zero;
        logic height_zero;
        logic count_zero;
        logic opaque;
        logic cursor_ok;
        logic q_next_ok;
        logic rd_ctrl;
        logic out_full;
    } t_sts;

endpackage

### design/rspb_ctrl.sv
// Sequencer for pixel access, cel setup and run-length drawing.
module rspb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  rspb_pkg::t_op  i_op,
    input  rspb_pkg::t_sts i_sts,
    output rspb_pkg::t_cmd o_cmd,
    output logic           o_accept
);
    import rspb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PWR,
        S_PRD,
        S_PRD_OUT,
        S_CEL,
        S_RUN,
        S_PIX,
        S_CHK,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    t_cmd   w_cmd;

    assign o_accept   = i_s_tvalid && r_ready;
    assign o_s_tready = r_ready;
    assign o_cmd      = w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (o_accept) begin
                    unique case (i_op)
                        OP_WRITE: n_state = S_PWR;
                        OP_READ:  n_state = S_PRD;
                        OP_CEL:   n_state = S_CEL;
                        OP_RUN:   n_state = S_RUN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_PWR: begin
                w_cmd.pix_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_PRD: begin
                w_cmd.pix_read = 1'b1;
                n_state        = S_PRD_OUT;
            end
            S_PRD_OUT: begin
                if (!i_sts.out_full) begin
                    w_cmd.push_read = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_CEL: begin
                w_cmd.cel_start = 1'b1;
                n_state         = i_sts.height_zero ? S_DONE : S_IDLE;
            end
            S_RUN: begin
                if (i_sts.rows_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.run_zero) begin
                    w_cmd.row_end = 1'b1;
                    n_state       = i_sts.rows_one ? S_DONE : S_IDLE;
                end else begin
                    w_cmd.run_load = 1'b1;
                    n_state        = S_PIX;
                end
            end
            S_PIX: begin
                if (i_sts.count_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.opaque && i_sts.cursor_ok) begin
                    w_cmd.rd_cursor = 1'b1;
                    n_state         = S_CHK;
                end else begin
                    w_cmd.step = 1'b1;
                end
            end
            S_CHK: begin
                w_cmd.save_real = 1'b1;
                if (!i_sts.rd_ctrl) begin
                    w_cmd.plot     = 1'b1;
                    w_cmd.plot_chk = 1'b1;
                    w_cmd.step     = 1'b1;
                    n_state        = S_PIX;
                end else if (i_sts.q_next_ok) begin
                    w_cmd.rd_walk = 1'b1;
                    n_state       = S_WALK;
                end else begin
                    w_cmd.plot        = 1'b1;
                    w_cmd.plot_chk    = 1'b1;
                    w_cmd.plot_bottom = 1'b1;
                    w_cmd.step        = 1'b1;
                    n_state           = S_PIX;
                end
            end
            S_WALK: begin
                if (!i_sts.rd_ctrl) begin
                    w_cmd.plot = 1'b1;
                    w_cmd.step = 1'b1;
                    n_state    = S_PIX;
                end else if (i_sts.q_next_ok) begin
                    w_cmd.rd_walk = 1'b1;
                end else begin
                    w_cmd.plot        = 1'b1;
                    w_cmd.plot_bottom = 1'b1;
                    w_cmd.step        = 1'b1;
                    n_state           = S_PIX;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    w_cmd.push_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

### design/rspb_datapath.sv
// Screen store, cel registers, priority resolve and result register.
module rspb_datapath #(
    parameter int SCREEN_WIDTH  = rspb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rspb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [rspb_pkg::S_TDATA_W-1:0] i_tdata,
    input  rspb_pkg::t_cmd                 i_cmd,
    output rspb_pkg::t_sts                 o_sts,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rspb_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [0:0]                     o_m_tuser
);
    import rspb_pkg::*;

    localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int POS_RAW    = $clog2(STORE_SIZE + 2 * SCREEN_WIDTH + 512) + 1;
    localparam int POS_W      = (POS_RAW > 17) ? POS_RAW : 17;

    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_pos SIZE_P = t_pos'(STORE_SIZE);
    localparam t_pos W_P    = t_pos'(SCREEN_WIDTH);
    localparam t_pos H_P    = t_pos'(SCREEN_HEIGHT);
    localparam t_pos NEG1   = t_pos'(-1);
    localparam t_pos ONE    = t_pos'(1);
    localparam t_pos ZERO   = t_pos'(0);

    function automatic t_pos sat_pos(input t_pos v);
        t_pos r;
        r = v;
        if (v < NEG1) r = NEG1;
        if (v > SIZE_P) r = SIZE_P;
        return r;
    endfunction

    // latched request
    logic [14:0]       r_pix_addr;
    logic [7:0]        r_pix_value;
    logic signed [9:0] r_cel_x;
    logic signed [9:0] r_cel_y;
    logic [3:0]        r_cel_prio;
    logic [3:0]        r_cel_transp;
    logic              r_cel_mirror;
    logic [7:0]        r_cel_width;
    logic [7:0]        r_cel_height;
    logic [7:0]        r_run_byte;

    // cel state
    t_pos       r_cursor;
    t_pos       r_row_start;
    logic [7:0] r_rows_left;
    logic [3:0] r_prio;
    logic [3:0] r_transp;
    logic       r_mirror;
    logic       r_hidden;
    logic [3:0] r_colour;
    logic [3:0] r_count;
    t_pos       r_q;
    logic [3:0] r_real;

    logic [7:0] r_mem [STORE_SIZE];
    logic [7:0] r_rd_data;

    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_value;
    logic       r_out_hidden;

    t_pos       w_pix_pos;
    logic       w_pix_ok;
    logic       w_cursor_ok;
    t_pos       w_q_next;
    t_pos       w_x;
    t_pos       w_y;
    t_pos       w_xc;
    t_pos       w_yc;
    t_pos       w_moff;
    t_pos       w_cel_pos;
    t_pos       w_row_next;
    t_pos       w_step;
    logic [3:0] w_rd_hi;
    logic [3:0] w_real;
    logic [3:0] w_eff;
    logic       w_draw;
    logic [3:0] w_wprio;
    logic              w_we;
    logic              w_re;
    logic [ADDR_W-1:0] w_wa;
    logic [ADDR_W-1:0] w_ra;
    logic [7:0]        w_wd;

    always_comb begin
        w_pix_pos   = t_pos'(r_pix_addr);
        w_pix_ok    = w_pix_pos < SIZE_P;
        w_cursor_ok = (r_cursor >= ZERO) && (r_cursor < SIZE_P);
        w_q_next    = r_q + W_P;

        w_x  = t_pos'(r_cel_x);
        w_y  = t_pos'(r_cel_y);
        w_xc = w_x;
        if (w_x < ZERO) w_xc = ZERO;
        if (w_x >= W_P) w_xc = W_P - ONE;
        w_yc = w_y;
        if (w_y < ZERO) w_yc = ZERO;
        if (w_y >= H_P) w_yc = H_P - ONE;
        w_moff    = r_cel_mirror ? (t_pos'(r_cel_width) - ONE) : ZERO;
        w_cel_pos = sat_pos(w_xc + t_pos'(w_yc * W_P) + w_moff);

        w_row_next = sat_pos(r_row_start + W_P);
        w_step     = sat_pos(r_cursor + (r_mirror ? NEG1 : ONE));

        w_rd_hi = r_rd_data[7:4];
        w_real  = i_cmd.plot_chk ? w_rd_hi : r_real;
        w_eff   = i_cmd.plot_bottom ? PRIO_BOTTOM : w_rd_hi;
        w_draw  = r_prio >= w_eff;
        w_wprio = (w_real < PRIO_CTRL) ? w_real : r_prio;

        w_we = 1'b0;
        w_wa = w_pix_pos[ADDR_W-1:0];
        w_wd = r_pix_value;
        if (i_cmd.pix_write && w_pix_ok) begin
            w_we = 1'b1;
        end else if (i_cmd.plot && w_draw) begin
            w_we = 1'b1;
            w_wa = r_cursor[ADDR_W-1:0];
            w_wd = {w_wprio, r_colour};
        end

        w_re = 1'b0;
        w_ra = w_pix_pos[ADDR_W-1:0];
        if (i_cmd.pix_read && w_pix_ok) begin
            w_re = 1'b1;
        end else if (i_cmd.rd_cursor) begin
            w_re = 1'b1;
            w_ra = r_cursor[ADDR_W-1:0];
        end else if (i_cmd.rd_walk) begin
            w_re = 1'b1;
            w_ra = w_q_next[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix_addr   <= i_tdata[14:0];
            r_pix_value  <= i_tdata[22:15];
            r_cel_x      <= i_tdata[32:23];
            r_cel_y      <= i_tdata[42:33];
            r_cel_prio   <= i_tdata[46:43];
            r_cel_transp <= i_tdata[50:47];
            r_cel_mirror <= i_tdata[51];
            r_cel_width  <= i_tdata[59:52];
            r_cel_height <= i_tdata[67:60];
            r_run_byte   <= i_tdata[75:68];
        end
        if (i_cmd.run_load) begin
            r_colour <= r_run_byte[7:4];
        end
        if (i_cmd.rd_cursor) begin
            r_q <= r_cursor;
        end else if (i_cmd.rd_walk) begin
            r_q <= w_q_next;
        end
        if (i_cmd.save_real) begin
            r_real <= w_rd_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor     <= ZERO;
            r_row_start  <= ZERO;
            r_rows_left  <= '0;
            r_prio       <= '0;
            r_transp     <= '0;
            r_mirror     <= 1'b0;
            r_hidden     <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_out_kind   <= KIND_READ;
            r_out_value  <= '0;
            r_out_hidden <= 1'b0;
        end else begin
            if (i_cmd.cel_start) begin
                r_prio      <= r_cel_prio;
                r_transp    <= r_cel_transp;
                r_mirror    <= r_cel_mirror;
                r_rows_left <= r_cel_height;
                r_hidden    <= 1'b1;
                r_row_start <= w_cel_pos;
                r_cursor    <= w_cel_pos;
            end
            if (i_cmd.row_end) begin
                r_row_start <= w_row_next;
                r_cursor    <= w_row_next;
                r_rows_left <= r_rows_left - 8'd1;
            end
            if (i_cmd.run_load) begin
                r_count <= r_run_byte[3:0];
            end
            if (i_cmd.plot && w_draw) begin
                r_hidden <= 1'b0;
            end
            if (i_cmd.step) begin
                r_cursor <= w_step;
                r_count  <= r_count - 4'd1;
            end
            if (i_cmd.push_read) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= KIND_READ;
                r_out_value  <= w_pix_ok ? r_rd_data : 8'h00;
                r_out_hidden <= 1'b0;
            end else if (i_cmd.push_done) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= KIND_CEL;
                r_out_value  <= 8'h00;
                r_out_hidden <= r_hidden;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.rows_zero   = (r_rows_left == 8'd0);
        o_sts.rows_one    = (r_rows_left == 8'd1);
        o_sts.run_zero    = (r_run_byte == 8'd0);
        o_sts.height_zero = (r_cel_height == 8'd0);
        o_sts.count_zero  = (r_count == 4'd0);
        o_sts.opaque      = (r_colour != r_transp);
        o_sts.cursor_ok   = w_cursor_ok;
        o_sts.q_next_ok   = (w_q_next < SIZE_P);
        o_sts.rd_ctrl     = (w_rd_hi < PRIO_CTRL);
        o_sts.out_full    = r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_hidden, r_out_value};
    assign o_m_tuser  = r_out_kind;

endmodule

### design/rle_sprite_priority_blit_unit.sv
// Each request is carried out in full before the next is accepted; a finishing cel also
// passes through a done state that posts its result.
// A run byte draws pixel by pixel: a skipped pixel only steps, a drawn pixel reads the store
// first, and over a control line the column is walked down until it is resolved.
// A read or cel-finished result waits while the previous one is still held.
// Reset clears sequencer, cel state and result register; store is undefined until written.
module rle_sprite_priority_blit_unit #(
    parameter int SCREEN_WIDTH  = rspb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rspb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // pixel_address, pixel_value, cel_x, cel_y, cel_priority, cel_transparent,
    // cel_mirror, cel_width, cel_height, run_byte, zero pad
    input  logic [rspb_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // read_value, cel_hidden, zero pad
    output logic [rspb_pkg::M_TDATA_W-1:0] o_m_tdata,
    // result_kind
    output logic [0:0]                     o_m_tuser
);
    import rspb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_accept;

    rspb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (t_op'(i_s_tuser)),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_accept   (w_accept)
    );

    rspb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_tdata    (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### tb/rle_sprite_priority_blit_unit_tb.sv
// Self-checking testbench for the run-length sprite blitter with a priority screen store.
module rle_sprite_priority_blit_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rspb_pkg::*;

    localparam int SW          = SCREEN_WIDTH_DEF;
    localparam int SH          = SCREEN_HEIGHT_DEF;
    localparam int STORE       = SW * SH;
    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 3000;
    localparam int PHASE_ITEMS = 230;
    // only the bottom rows are drawn into and read back, so only they are preloaded
    localparam int BAND_ROWS   = 6;
    localparam int BAND_BASE   = (SH - BAND_ROWS) * SW;

    localparam logic [7:0] CTRL_FLOOR  = {PRIO_CTRL, 4'h0};
    localparam logic [7:0] BOTTOM_PRIO = {PRIO_BOTTOM, 4'h0};

    typedef struct {
        t_op        op;
        logic [14:0] addr;
        logic [7:0] pval;
        logic [9:0] cx;
        logic [9:0] cy;
        logic [3:0] cprio;
        logic [3:0] ctransp;
        logic       cmir;
        logic [7:0] cwid;
        logic [7:0] chgt;
        logic [7:0] run;
    } t_blit_req;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       hidden;
    } t_blit_res;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic [1:0]           s_user  = '0;
    logic                 m_ready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]           o_m_tuser;

    t_blit_req req_q[$];
    t_blit_res result_q[$];
    t_blit_req cur_req;
    logic      s_fire        = 1'b0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        idle_cycles   = 0;
    int        mismatches    = 0;

    // shadow of the block
    logic [7:0] screen_img [STORE];
    int         cursor_pos    = 0;
    int         row_base      = 0;
    int         rows_rem      = 0;
    logic [3:0] sprite_prio   = '0;
    logic [3:0] sprite_transp = '0;
    logic       sprite_mirror = 1'b0;
    logic       cel_unseen    = 1'b1;

    rle_sprite_priority_blit_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int clamp_pos(input int v);
        if (v < -1) return -1;
        if (v > STORE) return STORE;
        return v;
    endfunction

    task automatic plot_pixel(input int pos, input logic [3:0] colour);
        logic [7:0] cur_pr;
        logic [7:0] eff;
        logic [7:0] spr;
        logic       found;
        int         q;
        if (pos < 0 || pos >= STORE) return;
        cur_pr = screen_img[pos] & 8'hf0;
        eff    = cur_pr;
        if (cur_pr < CTRL_FLOOR) begin
            eff   = BOTTOM_PRIO;
            found = 1'b0;
            q     = pos;
            while (q < STORE && !found) begin
                if ((screen_img[q] & 8'hf0) >= CTRL_FLOOR) begin
                    eff   = screen_img[q] & 8'hf0;
                    found = 1'b1;
                end
                q += SW;
            end
        end
        spr = {sprite_prio, 4'h0};
        if (spr >= eff) begin
            screen_img[pos] = {(cur_pr < CTRL_FLOOR) ? cur_pr[7:4] : sprite_prio, colour};
            cel_unseen      = 1'b0;
        end
    endtask

    task automatic blit_predict(input t_blit_req r);
        t_blit_res  res;
        int         x;
        int         y;
        int         n;
        logic [3:0] colour;
        case (r.op)
            OP_WRITE: begin
                if (r.addr < STORE) screen_img[r.addr] = r.pval;
            end
            OP_READ: begin
                res.kind   = KIND_READ;
                res.value  = (r.addr < STORE) ? screen_img[r.addr] : 8'h00;
                res.hidden = 1'b0;
                result_q.insert(result_q.size(), res);
            end
            OP_CEL: begin
                x = int'($signed(r.cx));
                y = int'($signed(r.cy));
                if (x < 0) x = 0;
                if (y < 0) y = 0;
                if (x >= SW) x = SW - 1;
                if (y >= SH) y = SH - 1;
                sprite_prio   = r.cprio;
                sprite_transp = r.ctransp;
                sprite_mirror = r.cmir;
                rows_rem      = int'(r.chgt);
                cel_unseen    = 1'b1;
                row_base      = clamp_pos(x + y * SW + (r.cmir ? int'(r.cwid) - 1 : 0));
                cursor_pos    = row_base;
                if (rows_rem == 0) begin
                    res.kind   = KIND_CEL;
                    res.value  = 8'h00;
                    res.hidden = 1'b1;
                    result_q.insert(result_q.size(), res);
                end
            end
            OP_RUN: begin
                if (rows_rem != 0) begin
                    if (r.run == 8'h00) begin
                        row_base   = clamp_pos(row_base + SW);
                        cursor_pos = row_base;
                        rows_rem--;
                        if (rows_rem == 0) begin
                            res.kind   = KIND_CEL;
                            res.value  = 8'h00;
                            res.hidden = cel_unseen;
                            result_q.insert(result_q.size(), res);
                        end
                    end else begin
                        colour = r.run[7:4];
                        for (n = int'(r.run[3:0]); n != 0; n--) begin
                            if (colour != sprite_transp) plot_pixel(cursor_pos, colour);
                            cursor_pos = clamp_pos(cursor_pos + (sprite_mirror ? -1 : 1));
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // driver: one request held until accepted
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || s_fire)) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_req = req_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= {4'h0, cur_req.run, cur_req.chgt, cur_req.cwid, cur_req.cmir,
                            cur_req.ctransp, cur_req.cprio, cur_req.cy, cur_req.cx,
                            cur_req.pval, cur_req.addr};
                s_user  <= cur_req.op;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_blit_res want;
        logic      m_fire;
        s_fire = s_valid && o_s_tready;
        m_fire = o_m_tvalid && m_ready;
        if (i_rst_n) begin
            if (m_fire) begin
                if (result_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result at %0t: kind %0d data %04h",
                                            $time, o_m_tuser[0], o_m_tdata));
                end else begin
                    want = result_q.pop_front();
                    if (o_m_tuser[0] !== want.kind || o_m_tdata[7:0] !== want.value ||
                        o_m_tdata[8] !== want.hidden)
                        note_mismatch($sformatf(
                            "mismatch at %0t: exp kind %0d value %02h hidden %0d, got %0d %02h %0d",
                            $time, want.kind, want.value, want.hidden,
                            o_m_tuser[0], o_m_tdata[7:0], o_m_tdata[8]));
                end
            end
            if (s_fire) blit_predict(cur_req);
            if (s_fire || m_fire) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_blit_req noise_req(input t_op op);
        t_blit_req r;
        r.op      = op;
        r.addr    = 15'($urandom);
        r.pval    = 8'($urandom);
        r.cx      = 10'($urandom);
        r.cy      = 10'($urandom);
        r.cprio   = 4'($urandom);
        r.ctransp = 4'($urandom);
        r.cmir    = 1'($urandom);
        r.cwid    = 8'($urandom);
        r.chgt    = 8'($urandom);
        r.run     = 8'($urandom);
        return r;
    endfunction

    function automatic logic [7:0] rand_pix();
        logic [3:0] pr;
        logic [3:0] col;
        if ($urandom_range(4) == 0) pr = 4'($urandom_range(2));
        else pr = 4'($urandom_range(15, 3));
        col = 4'($urandom);
        return {pr, col};
    endfunction

    task automatic push_write(input int a, input logic [7:0] v);
        t_blit_req r;
        r      = noise_req(OP_WRITE);
        r.addr = 15'(a);
        r.pval = v;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic push_read(input int a);
        t_blit_req r;
        r      = noise_req(OP_READ);
        r.addr = 15'(a);
        req_q.insert(req_q.size(), r);
    endtask

    task automatic push_cel(input logic [9:0] x, input logic [9:0] y, input logic [3:0] p,
                            input logic [3:0] t, input logic m, input logic [7:0] w,
                            input logic [7:0] h);
        t_blit_req r;
        r         = noise_req(OP_CEL);
        r.cx      = x;
        r.cy      = y;
        r.cprio   = p;
        r.ctransp = t;
        r.cmir    = m;
        r.cwid    = w;
        r.chgt    = h;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic push_run(input logic [7:0] b);
        t_blit_req r;
        r     = noise_req(OP_RUN);
        r.run = b;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic drain();
        while (req_q.size() != 0 || s_valid || result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int sp, input int rp);
        int         count;
        int         pick;
        int         addr;
        int         rows;
        int         nrun;
        int         i;
        int         j;
        int         xi;
        int         yi;
        int         c;
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic [3:0] p;
        logic [3:0] t;
        logic [3:0] col;
        logic [3:0] len;
        logic       mir;
        send_idle_pct = sp;
        stall_pct     = rp;
        count         = 0;
        while (count < PHASE_ITEMS) begin
            pick = int'($urandom_range(99));
            if (pick < 22) begin
                if ($urandom_range(19) == 0) addr = int'($urandom_range(32767, STORE));
                else addr = int'($urandom_range(STORE - 1, BAND_BASE));
                if (pick < 12) push_write(addr, rand_pix());
                else push_read(addr);
                count++;
            end else if (pick < 25) begin
                push_run(8'($urandom));
            end else begin
                if ($urandom_range(7) == 0) x = 10'($urandom);
                else x = 10'($urandom_range(SW - 1));
                // start at least two rows into the preloaded band
                if ($urandom_range(7) == 0) y = 10'($urandom_range(511, SH));
                else y = 10'($urandom_range(SH - 1, SH - BAND_ROWS + 2));
                if ($urandom_range(1) == 0) w = 8'($urandom_range(16, 1));
                else w = 8'($urandom);
                pick = int'($urandom_range(19));
                if (pick == 0) h = 8'd0;
                else if (pick < 3) h = 8'($urandom_range(255, 5));
                else h = 8'($urandom_range(4, 1));
                p   = 4'($urandom);
                t   = 4'($urandom);
                mir = 1'($urandom);
                push_cel(x, y, p, t, mir, w, h);
                count++;
                // tall cels are cut short and left for the next cel start to abandon
                rows = (h > 8'd4) ? int'($urandom_range(3, 1)) : int'(h);
                for (i = 0; i < rows; i++) begin
                    nrun = ($urandom_range(19) == 0) ? int'($urandom_range(8, 5))
                                                     : int'($urandom_range(4));
                    for (j = 0; j < nrun; j++) begin
                        if ($urandom_range(3) == 0) col = t;
                        else col = 4'($urandom);
                        len = 4'($urandom_range(15, 1));
                        push_run({col, len});
                        count++;
                    end
                    push_run(8'h00);
                    count++;
                end
                xi = int'($signed(x));
                yi = int'($signed(y));
                if (xi < 0) xi = 0;
                if (yi < 0) yi = 0;
                if (xi >= SW) xi = SW - 1;
                if (yi >= SH) yi = SH - 1;
                repeat ($urandom_range(3)) begin
                    c    = int'($urandom_range(15));
                    addr = yi * SW + xi + int'($urandom_range(3)) * SW
                           + (mir ? int'(w) - 1 - c : c);
                    if (addr >= BAND_BASE && addr < STORE) begin
                        push_read(addr);
                        count++;
                    end
                end
            end
        end
        drain();
    endtask

    initial begin : stimulus
        int k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = BAND_BASE; k < STORE; k++) push_write(k, rand_pix());

        push_write(0, 8'hff);
        push_read(0);
        push_write(STORE - 1, 8'h00);
        push_read(STORE - 1);
        push_write(32767, 8'h5a);
        push_read(32767);
        push_read(STORE);
        // zero height, then a run byte with no cel
        push_cel(10'd0, 10'd0, 4'hf, 4'h0, 1'b0, 8'd8, 8'd0);
        push_run(8'h37);
        // mirrored at width 0 from the corner: starts before the store
        push_cel(10'h3fb, 10'h200, 4'hf, 4'h0, 1'b1, 8'd0, 8'd1);
        push_run(8'h15);
        push_run(8'h00);
        // clamped to the last pixel, run falls off the end over a control line
        push_cel(10'h1ff, 10'h1ff, 4'hf, 4'h0, 1'b0, 8'hff, 8'd2);
        push_run(8'haf);
        push_run(8'h00);
        push_run(8'h05);
        push_run(8'h00);
        push_read(STORE - 1);
        // cel abandoned by a new start, then an overlong mirrored row
        push_cel(10'd10, 10'(SH - 3), 4'h8, 4'hf, 1'b0, 8'd16, 8'd3);
        push_run(8'h2f);
        push_run(8'hf3);
        push_cel(10'd12, 10'(SH - 3), 4'h0, 4'h1, 1'b1, 8'd4, 8'd1);
        push_run(8'h3f);
        push_run(8'h4f);
        push_run(8'h5f);
        push_run(8'h00);
        push_read((SH - 3) * SW + 10);
        drain();

        run_phase(0, 0);
        run_phase(80, 0);
        run_phase(0, 80);
        run_phase(20, 20);

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
